FILE: design/sgsa_pkg.sv
// Shared types, constants and helpers for the sparse grid slot allocator.
`timescale 1ns / 1ps
package sgsa_pkg;

    // Default geometry
    localparam int CELLS_PER_SIDE_DEF = 128;
    localparam int SLOT_COUNT_DEF     = 512;
    localparam int COORD_OFFSET_DEF   = 512;

    // Fixed field widths
    localparam int COORD_W    = 16;
    localparam int SUM_W      = COORD_W + 2;
    localparam int BYTE_W     = 8;
    localparam int OUT_W      = 9;
    localparam int SLOT_BYTES = 64;
    localparam int SUB_W      = $clog2(SLOT_BYTES);
    localparam int CNT_W      = $clog2(SLOT_BYTES) + 1;
    localparam int CELL_MAX_W = 20;
    localparam int SCAN_W     = 16;
    localparam int SCAN_IDX_W = $clog2(SCAN_W);

    localparam logic [BYTE_W-1:0] BYTE_FREE = 8'hff;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_ERASE = 1'b1
    } op_e;

    // Classified request handed from front to back
    typedef struct packed {
        op_e                   op;
        logic                  hit;
        logic [CELL_MAX_W-1:0] cell_addr;
        logic [SUB_W-1:0]      sub;
        logic [BYTE_W-1:0]     val;
    } cmd_t;

    // Result of one request
    typedef struct packed {
        logic             ok;
        logic [OUT_W-1:0] slot_used;
        logic [OUT_W-1:0] high_water;
    } res_t;

    // Back-end status seen by the front
    typedef struct packed {
        logic clearing;
    } back_status_t;

    function automatic logic [OUT_W-1:0] to_out(input logic [31:0] v);
        return v[OUT_W-1:0];
    endfunction

endpackage

FILE: design/sparse_grid_slot_allocator.sv
// Top level of the sparse grid slot allocator.
//
//   channel   direction  handshake       payload
//   request   in         push / full     op, coord_x, coord_y, byte_value
//   result    out        pop / empty     ok, slot_used, high_water
//
// After reset a clearing pass sets every store byte free; full stays high meanwhile.
// A request out of range ends in the map state, and an erase of a cell with no
// slot ends once the cell map is read. A cell with a mapped slot goes on to read
// and update the slot byte and count; a write to a cell with no slot first scans
// the free bitmap word by word, 16 slots to a word, to allocate a slot.
// A request passes through the request queue before the back end picks it up.
// Requests are carried out one at a time; two-entry queues on each side let
// input and output stall independently.
`timescale 1ns / 1ps
module sparse_grid_slot_allocator
    import sgsa_pkg::*;
#(
    parameter int CELLS_PER_SIDE = CELLS_PER_SIDE_DEF,
    parameter int SLOT_COUNT     = SLOT_COUNT_DEF,
    parameter int COORD_OFFSET   = COORD_OFFSET_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic                      op,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    input  logic [BYTE_W-1:0]         byte_value,
    output logic                      empty,
    input  logic                      pop,
    output logic                      ok,
    output logic [OUT_W-1:0]          slot_used,
    output logic [OUT_W-1:0]          high_water
);

    back_status_t status;
    logic         cq_push;
    logic         cq_full;
    logic         cq_pop;
    logic         cq_empty;
    cmd_t         cq_wdata;
    cmd_t         cq_rdata;
    logic         rq_push;
    logic         rq_full;
    res_t         rq_wdata;
    res_t         rq_rdata;

    // Classify requests
    sgsa_front #(
        .CELLS_PER_SIDE (CELLS_PER_SIDE),
        .COORD_OFFSET   (COORD_OFFSET)
    ) u_front (
        .push       (push),
        .full       (full),
        .op         (op),
        .coord_x    (coord_x),
        .coord_y    (coord_y),
        .byte_value (byte_value),
        .status     (status),
        .q_full     (cq_full),
        .q_push     (cq_push),
        .q_cmd      (cq_wdata)
    );

    // Queue requests between front and back
    sgsa_fifo #(
        .WIDTH ($bits(cmd_t))
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cq_push),
        .wdata (cq_wdata),
        .full  (cq_full),
        .pop   (cq_pop),
        .rdata (cq_rdata),
        .empty (cq_empty)
    );

    // Carry out requests
    sgsa_back #(
        .CELLS_PER_SIDE (CELLS_PER_SIDE),
        .SLOT_COUNT     (SLOT_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cq_empty),
        .cmd_data  (cq_rdata),
        .cmd_pop   (cq_pop),
        .res_full  (rq_full),
        .res_push  (rq_push),
        .res_data  (rq_wdata),
        .status    (status)
    );

    // Queue results
    sgsa_fifo #(
        .WIDTH ($bits(res_t))
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rq_push),
        .wdata (rq_wdata),
        .full  (rq_full),
        .pop   (pop),
        .rdata (rq_rdata),
        .empty (empty)
    );

    assign ok         = rq_rdata.ok;
    assign slot_used  = rq_rdata.slot_used;
    assign high_water = rq_rdata.high_water;

endmodule

FILE: design/sgsa_fifo.sv
// Two-entry queue used between front, back and result ports.
`timescale 1ns / 1ps
module sgsa_fifo
    import sgsa_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Store entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

FILE: design/sgsa_front.sv
// Front end: accepts requests and classifies coordinates into cell and byte.
`timescale 1ns / 1ps
module sgsa_front
    import sgsa_pkg::*;
#(
    parameter int CELLS_PER_SIDE = CELLS_PER_SIDE_DEF,
    parameter int COORD_OFFSET   = COORD_OFFSET_DEF
)
(
    input  logic                      push,
    output logic                      full,
    input  logic                      op,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    input  logic [BYTE_W-1:0]         byte_value,
    input  back_status_t              status,
    input  logic                      q_full,
    output logic                      q_push,
    output cmd_t                      q_cmd
);

    localparam int CW     = $clog2(CELLS_PER_SIDE);
    localparam int DIV_W  = SUM_W - 3;

    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic                    in_x;
    logic                    in_y;
    logic [DIV_W-1:0]        col;
    logic [DIV_W-1:0]        row;

    // Offset the coordinates
    assign sum_x = SUM_W'(coord_x) + $signed(SUM_W'(COORD_OFFSET));
    assign sum_y = SUM_W'(coord_y) + $signed(SUM_W'(COORD_OFFSET));

    // Truncating divide by eight: sums of -7..-1 fold into cell zero
    always_comb
    begin
        if (sum_x < 0)
        begin
            in_x = (sum_x[SUM_W-1:3] == '1) && (sum_x[2:0] != 3'd0);
            col  = '0;
        end
        else
        begin
            col  = sum_x[SUM_W-1:3];
            in_x = (col < DIV_W'(CELLS_PER_SIDE));
        end
        if (sum_y < 0)
        begin
            in_y = (sum_y[SUM_W-1:3] == '1) && (sum_y[2:0] != 3'd0);
            row  = '0;
        end
        else
        begin
            row  = sum_y[SUM_W-1:3];
            in_y = (row < DIV_W'(CELLS_PER_SIDE));
        end
    end

    // Build request for the back end
    always_comb
    begin
        q_cmd.op        = op_e'(op);
        q_cmd.hit       = in_x && in_y;
        q_cmd.cell_addr = (CELL_MAX_W'(col[CW-1:0]) << CW) | CELL_MAX_W'(row[CW-1:0]);
        q_cmd.sub       = {coord_y[2:0], coord_x[2:0]};
        q_cmd.val       = byte_value;
    end

    // Hold off requests while the queue is full or the stores are being cleared
    assign full   = q_full || status.clearing;
    assign q_push = push && !full;

endmodule

FILE: design/sgsa_back.sv
// Back end: cell map, slot store, occupancy counts and slot allocation.
`timescale 1ns / 1ps
module sgsa_back
    import sgsa_pkg::*;
#(
    parameter int CELLS_PER_SIDE = CELLS_PER_SIDE_DEF,
    parameter int SLOT_COUNT     = SLOT_COUNT_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cmd_empty,
    input  cmd_t         cmd_data,
    output logic         cmd_pop,
    input  logic         res_full,
    output logic         res_push,
    output res_t         res_data,
    output back_status_t status
);

    localparam int SW     = $clog2(SLOT_COUNT);
    localparam int CMW    = 2 * $clog2(CELLS_PER_SIDE);
    localparam int BW     = SW + SUB_W;
    localparam int CLRW   = (BW > CMW) ? BW : CMW;
    localparam int NWORDS = SLOT_COUNT / SCAN_W;
    localparam int WW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MAP,
        S_MAPD,
        S_SCAN,
        S_RD,
        S_RDD
    } state_e;

    state_e                state_reg;
    cmd_t                  cmd_reg;
    logic [SW-1:0]         slot_reg;
    logic [SW-1:0]         hw_reg;
    logic [WW-1:0]         word_reg;
    logic [CLRW-1:0]       clr_reg;
    logic [SLOT_COUNT-1:0] free_reg;

    // Memories
    logic [SW-1:0]     cell_map   [CELLS_PER_SIDE*CELLS_PER_SIDE];
    logic [BYTE_W-1:0] slot_store [SLOT_COUNT*SLOT_BYTES];
    logic [CNT_W-1:0]  cnt_mem    [SLOT_COUNT];

    logic [SW-1:0]     map_rd;
    logic [BYTE_W-1:0] byte_rd;
    logic [CNT_W-1:0]  cnt_rd;

    logic              map_we;
    logic [CMW-1:0]    map_wa;
    logic [SW-1:0]     map_wd;
    logic              store_we;
    logic [BW-1:0]     store_wa;
    logic [BYTE_W-1:0] store_wd;
    logic              cnt_we;
    logic [SW-1:0]     cnt_wa;
    logic [CNT_W-1:0]  cnt_wd;

    logic [CMW-1:0]    cell_idx;
    logic [BW-1:0]     byte_addr;
    logic [SCAN_W-1:0] scan_bits;
    logic              scan_hit;
    logic [SCAN_IDX_W-1:0] scan_pick;
    logic [SW-1:0]     scan_slot;
    logic [BYTE_W-1:0] new_byte;
    logic [CNT_W-1:0]  new_cnt;
    logic [SW-1:0]     hw_new;
    logic              start;

    assign cell_idx  = cmd_reg.cell_addr[CMW-1:0];
    assign byte_addr = {slot_reg, cmd_reg.sub};
    assign status.clearing = (state_reg == S_CLEAR);
    assign start     = (state_reg == S_IDLE) && !cmd_empty && !res_full;
    assign cmd_pop   = start;

    // Pick the lowest free slot in the current bitmap word, never slot zero
    always_comb
    begin
        scan_bits = free_reg[32'(word_reg) * SCAN_W +: SCAN_W];
        if (word_reg == '0)
        begin
            scan_bits[0] = 1'b0;
        end
        scan_hit  = |scan_bits;
        scan_pick = '0;
        for (int i = SCAN_W - 1; i >= 0; i--)
        begin
            if (scan_bits[i])
            begin
                scan_pick = SCAN_IDX_W'(i);
            end
        end
        scan_slot = SW'(32'(word_reg) * SCAN_W + 32'(scan_pick));
    end

    // Update byte and occupancy count of the target slot and the high water mark
    always_comb
    begin
        new_byte = (cmd_reg.op == OP_ERASE) ? BYTE_FREE : cmd_reg.val;
        new_cnt  = cnt_rd - CNT_W'(byte_rd != BYTE_FREE) + CNT_W'(new_byte != BYTE_FREE);
        hw_new   = (cmd_reg.op == OP_WRITE && slot_reg > hw_reg) ? slot_reg : hw_reg;
    end

    // Drive memory write ports and results
    always_comb
    begin
        map_we   = 1'b0;
        map_wa   = cell_idx;
        map_wd   = '0;
        store_we = 1'b0;
        store_wa = byte_addr;
        store_wd = new_byte;
        cnt_we   = 1'b0;
        cnt_wa   = slot_reg;
        cnt_wd   = new_cnt;
        res_push = 1'b0;
        res_data = '{ok: 1'b0, slot_used: '0, high_water: to_out(32'(hw_reg))};
        unique case (state_reg)
            S_CLEAR:
            begin
                map_we   = 1'b1;
                map_wa   = clr_reg[CMW-1:0];
                store_we = 1'b1;
                store_wa = clr_reg[BW-1:0];
                store_wd = BYTE_FREE;
                cnt_we   = 1'b1;
                cnt_wa   = clr_reg[SW-1:0];
                cnt_wd   = '0;
            end
            S_MAP:
            begin
                res_push = !cmd_reg.hit;
            end
            S_MAPD:
            begin
                if (cmd_reg.op == OP_ERASE && map_rd == '0)
                begin
                    res_push     = 1'b1;
                    res_data.ok  = 1'b1;
                end
            end
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    map_we = 1'b1;
                    map_wd = scan_slot;
                end
                else if (word_reg == WW'(NWORDS - 1))
                begin
                    res_push = 1'b1;
                end
            end
            S_RDD:
            begin
                store_we = 1'b1;
                cnt_we   = 1'b1;
                if (cmd_reg.op == OP_ERASE && new_cnt == '0)
                begin
                    map_we = 1'b1;
                end
                res_push = 1'b1;
                res_data = '{ok: 1'b1, slot_used: to_out(32'(slot_reg)),
                             high_water: to_out(32'(hw_new))};
            end
            default:
            begin
            end
        endcase
    end

    // Cell map
    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            cell_map[map_wa] <= map_wd;
        end
        map_rd <= cell_map[cell_idx];
    end

    // Slot byte store
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            slot_store[store_wa] <= store_wd;
        end
        byte_rd <= slot_store[byte_addr];
    end

    // Occupancy counts
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        cnt_rd <= cnt_mem[slot_reg];
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            hw_reg    <= '0;
            word_reg  <= '0;
            slot_reg  <= '0;
            free_reg  <= '1;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + CLRW'(1);
                    if (clr_reg == '1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg   <= cmd_data;
                        state_reg <= S_MAP;
                    end
                end
                S_MAP:
                begin
                    state_reg <= cmd_reg.hit ? S_MAPD : S_IDLE;
                end
                S_MAPD:
                begin
                    slot_reg <= map_rd;
                    word_reg <= '0;
                    if (map_rd != '0)
                    begin
                        state_reg <= S_RD;
                    end
                    else if (cmd_reg.op == OP_WRITE)
                    begin
                        state_reg <= S_SCAN;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_SCAN:
                begin
                    if (scan_hit)
                    begin
                        slot_reg  <= scan_slot;
                        state_reg <= S_RD;
                    end
                    else if (word_reg == WW'(NWORDS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        word_reg <= word_reg + WW'(1);
                    end
                end
                S_RD:
                begin
                    state_reg <= S_RDD;
                end
                S_RDD:
                begin
                    hw_reg             <= hw_new;
                    free_reg[slot_reg] <= (new_cnt == '0);
                    state_reg          <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: design/sgsa_checker.sv
// Port-level checks for the sparse grid slot allocator and their binding.
`timescale 1ns / 1ps
module sgsa_checker
    import sgsa_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             empty,
    input logic             pop,
    input logic             ok,
    input logic [OUT_W-1:0] slot_used,
    input logic [OUT_W-1:0] high_water
);

    // Hold a waiting result
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty)
        else $error("result dropped while stalled");

    a_hold_slot: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> $stable(slot_used))
        else $error("stalled result changed");

    // Failed request touches no slot
    a_fail_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !ok |-> slot_used == '0)
        else $error("failed request reports a slot");

    // Any touched slot was written at some point
    a_slot_below_mark: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && ok |-> high_water >= slot_used)
        else $error("slot above high water mark");

    // High water mark never drops between results
    a_mark_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop |=> empty || high_water >= $past(high_water))
        else $error("high water mark decreased");

endmodule

bind sparse_grid_slot_allocator sgsa_checker u_sgsa_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop        (pop),
    .ok         (ok),
    .slot_used  (slot_used),
    .high_water (high_water)
);

FILE: verif/tb_sparse_grid_slot_allocator.sv
// Self-checking testbench for the sparse grid slot allocator.
`timescale 1ns / 1ps
module tb_sparse_grid_slot_allocator;
    import sgsa_pkg::*;

    localparam int CELLS      = 128;
    localparam int SLOTS      = 512;
    localparam int OFFSET     = 512;
    localparam int STALL_LIMIT = 200000;
    localparam int RANDOM_REQS = 1272;

    typedef struct {
        op_e                      op;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [BYTE_W-1:0]         val;
    } grid_req_t;

    typedef struct {
        logic             ok;
        logic [OUT_W-1:0] slot_used;
        logic [OUT_W-1:0] high_water;
    } grid_res_t;

    // Directed row: request plus optional typed-in expectation
    typedef struct {
        grid_req_t req;
        bit        fixed;
        grid_res_t res;
    } stim_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      push;
    logic                      full;
    logic                      op;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic [BYTE_W-1:0]         byte_value;
    logic                      empty;
    logic                      pop;
    logic                      ok;
    logic [OUT_W-1:0]          slot_used;
    logic [OUT_W-1:0]          high_water;

    // Shadow copy of the grid state
    logic [8:0]        shadow_map [CELLS*CELLS];
    logic [BYTE_W-1:0] shadow_bytes [SLOTS*SLOT_BYTES];
    logic [8:0]        shadow_high;

    grid_res_t pending_results [$];
    grid_req_t req_queue [$];
    stim_row_t rows [$];
    int        mismatches;
    int        idle_cycles;
    int        sent_count;
    bit        timed_out;
    bit        hold_off;
    bit        calm;
    bit        feeding_done;

    sparse_grid_slot_allocator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .op         (op),
        .coord_x    (coord_x),
        .coord_y    (coord_y),
        .byte_value (byte_value),
        .empty      (empty),
        .pop        (pop),
        .ok         (ok),
        .slot_used  (slot_used),
        .high_water (high_water)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic bit slot_is_free(int s);
        for (int k = 0; k < SLOT_BYTES; k++)
        begin
            if (shadow_bytes[s*SLOT_BYTES + k] != BYTE_FREE)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Apply one request to the shadow grid and return its result
    function automatic grid_res_t grid_access(grid_req_t r);
        grid_res_t res;
        int        col;
        int        row;
        int        cell_no;
        int        sub;
        int        slot;
        col = (int'(r.x) + OFFSET) / 8;
        row = (int'(r.y) + OFFSET) / 8;
        res.ok = 1'b0;
        res.slot_used = '0;
        if (col >= 0 && col < CELLS && row >= 0 && row < CELLS)
        begin
            cell_no = col * CELLS + row;
            sub = int'(r.y[2:0]) * 8 + int'(r.x[2:0]);
            slot = int'(shadow_map[cell_no]);
            if (r.op == OP_WRITE)
            begin
                if (slot == 0)
                begin
                    for (int s = 1; s < SLOTS; s++)
                    begin
                        if (slot_is_free(s))
                        begin
                            slot = s;
                            break;
                        end
                    end
                    if (slot != 0)
                        shadow_map[cell_no] = slot[8:0];
                end
                if (slot != 0)
                begin
                    if (slot > int'(shadow_high))
                        shadow_high = slot[8:0];
                    shadow_bytes[slot*SLOT_BYTES + sub] = r.val;
                    res.ok = 1'b1;
                    res.slot_used = slot[8:0];
                end
            end
            else
            begin
                res.ok = 1'b1;
                if (slot != 0)
                begin
                    shadow_bytes[slot*SLOT_BYTES + sub] = BYTE_FREE;
                    if (slot_is_free(slot))
                        shadow_map[cell_no] = '0;
                    res.slot_used = slot[8:0];
                end
            end
        end
        res.high_water = shadow_high;
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic grid_req_t make_req(op_e o, int x, int y, int v);
        grid_req_t r;
        r.op = o;
        r.x = x[15:0];
        r.y = y[15:0];
        r.val = v[7:0];
        return r;
    endfunction

    function automatic grid_res_t make_res(bit k, int s, int h);
        grid_res_t r;
        r.ok = k;
        r.slot_used = s[8:0];
        r.high_water = h[8:0];
        return r;
    endfunction

    task automatic add_row(grid_req_t r, bit fixed, grid_res_t res);
        stim_row_t row;
        row.req = r;
        row.fixed = fixed;
        row.res = res;
        rows.push_back(row);
    endtask

    // Random request: mostly in-range on a small cell set, some wild coordinates
    function automatic grid_req_t random_req();
        grid_req_t r;
        int        pick;
        pick = $urandom_range(0, 99);
        r.op = ($urandom_range(0, 99) < 45) ? OP_ERASE : OP_WRITE;
        r.val = BYTE_W'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0)
            r.val = BYTE_FREE;
        if (pick < 8)
        begin
            r.x = COORD_W'($urandom);
            r.y = COORD_W'($urandom);
        end
        else if (pick < 15)
        begin
            r.x = COORD_W'(int'($urandom_range(0, 40)) - 530);
            r.y = COORD_W'(int'($urandom_range(0, 1100)) - 540);
        end
        else if (pick < 75)
        begin
            r.x = COORD_W'(int'($urandom_range(0, 23)) - 8);
            r.y = COORD_W'(int'($urandom_range(0, 23)) - 8);
        end
        else
        begin
            r.x = COORD_W'(int'($urandom_range(0, 1030)) - 519);
            r.y = COORD_W'(int'($urandom_range(0, 1030)) - 519);
        end
        return r;
    endfunction

    // Drive requests
    initial
    begin
        grid_req_t r;
        rst_n = 1'b0;
        push = 1'b0;
        op = 1'b0;
        coord_x = '0;
        coord_y = '0;
        byte_value = '0;
        feeding_done = 1'b0;
        sent_count = 0;
        shadow_high = '0;
        for (int i = 0; i < CELLS*CELLS; i++)
            shadow_map[i] = '0;
        for (int i = 0; i < SLOTS*SLOT_BYTES; i++)
            shadow_bytes[i] = BYTE_FREE;

        add_row(make_req(OP_ERASE, 0, 0, 0), 1'b1, make_res(1, 0, 0));
        add_row(make_req(OP_WRITE, -32768, 0, 8'h12), 1'b1, make_res(0, 0, 0));
        add_row(make_req(OP_WRITE, 0, 32767, 8'h12), 1'b1, make_res(0, 0, 0));
        add_row(make_req(OP_WRITE, 512, 0, 8'h12), 1'b1, make_res(0, 0, 0));
        add_row(make_req(OP_WRITE, 0, -520, 8'h12), 1'b1, make_res(0, 0, 0));
        add_row(make_req(OP_WRITE, -519, -519, 8'h00), 1'b1, make_res(1, 1, 1));
        add_row(make_req(OP_WRITE, -513, -513, 8'h5a), 1'b1, make_res(1, 1, 1));
        add_row(make_req(OP_WRITE, 511, 511, 8'hff), 1'b1, make_res(1, 2, 2));
        add_row(make_req(OP_WRITE, 510, 511, 8'h80), 1'b0, make_res(0, 0, 0));
        add_row(make_req(OP_WRITE, 100, -100, 8'hff), 1'b0, make_res(0, 0, 0));
        add_row(make_req(OP_WRITE, 200, 200, 8'h7f), 1'b0, make_res(0, 0, 0));
        add_row(make_req(OP_ERASE, 511, 511, 8'h00), 1'b0, make_res(0, 0, 0));
        add_row(make_req(OP_ERASE, 510, 511, 8'hff), 1'b0, make_res(0, 0, 0));
        add_row(make_req(OP_ERASE, -519, -519, 8'h00), 1'b0, make_res(0, 0, 0));
        add_row(make_req(OP_ERASE, -513, -513, 8'h00), 1'b0, make_res(0, 0, 0));
        add_row(make_req(OP_ERASE, 32767, -32768, 8'h00), 1'b1, make_res(0, 0, 3));
        add_row(make_req(OP_WRITE, -1, -1, 8'haa), 1'b0, make_res(0, 0, 0));
        add_row(make_req(OP_WRITE, 7, 7, 8'h55), 1'b0, make_res(0, 0, 0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
            req_queue.push_back(rows[i].req);
        for (int i = 0; i < RANDOM_REQS; i++)
            req_queue.push_back(random_req());

        // Fill the slot table once near the end so a write finds no free slot
        for (int i = 0; i < 520; i++)
            req_queue.push_back(make_req(OP_WRITE, -400 + 8 * (i % 100), 8 * (i / 100),
                                         $urandom_range(0, 254)));
        for (int i = 0; i < 40; i++)
            req_queue.push_back(random_req());

        for (int n = 0; req_queue.size() > 0; n++)
        begin
            r = req_queue.pop_front();
            while (!calm && $urandom_range(0, 99) < 26)
            begin
                push <= 1'b0;
                @(posedge clk);
            end
            push <= 1'b1;
            op <= r.op;
            coord_x <= r.x;
            coord_y <= r.y;
            byte_value <= r.val;
            @(posedge clk);
            while (full)
                @(posedge clk);
            sent_count++;
            if (n < rows.size() && rows[n].fixed)
            begin
                pending_results.push_back(rows[n].res);
                void'(grid_access(r));
            end
            else
                pending_results.push_back(grid_access(r));
        end
        push <= 1'b0;
        feeding_done = 1'b1;
    end

    // Calm stretch with no idling on either side
    initial
    begin
        calm = 1'b0;
        wait (sent_count > 300);
        calm = 1'b1;
        repeat (3000) @(posedge clk);
        calm = 1'b0;
    end

    // Long receiver hold-off so the block fills and stalls its input
    initial
    begin
        hold_off = 1'b0;
        wait (sent_count > 60);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
    end

    // Drain and compare results
    initial
    begin
        grid_res_t want;
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("unexpected result", 0, 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (ok !== want.ok)
                        report_mismatch("ok", ok, want.ok);
                    if (slot_used !== want.slot_used)
                        report_mismatch("slot_used", slot_used, want.slot_used);
                    if (high_water !== want.high_water)
                        report_mismatch("high_water", high_water, want.high_water);
                end
            end
            pop <= !hold_off && (calm || $urandom_range(0, 99) >= 26);
        end
    end

    // Watchdog on cycles without any accepted request or result
    initial
    begin
        idle_cycles = 0;
        timed_out = 1'b0;
        forever
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                timed_out = 1'b1;
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Finish once everything has drained
    initial
    begin
        mismatches = 0;
        wait (feeding_done);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (!empty)
            report_mismatch("extra result", 1, 0);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
